// ----- rtl/bounded_deque_with_search_top_macros.svh -----
// Assertion macros shared by the deque checker.
// Needs clk and arst_n in the scope of each use.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH

// Clocked check, quiet while reset is asserted
`define BDWS_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs during reset
`define BDWS_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bdws_pkg.sv -----
// Package for the bounded deque with search: widths, operation and status codes,
// controller state type. Used by every file of the block but the macro header.
`timescale 1ns / 1ps

package bdws_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WORD_W    = 32;
	localparam int POS_W     = 6;
	localparam int LEN_W     = 7;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_POP_FRONT  = 2'd1,
		OP_POP_BACK   = 2'd2,
		OP_SEARCH     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_DONE  = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_RESP
	} state_t;

endpackage

// ----- rtl/bdws_in_if.sv -----
// Request channel of the deque: valid/ready with operation and word.
// Depends on bdws_pkg.
`timescale 1ns / 1ps

interface bdws_in_if import bdws_pkg::*; ();
	logic                     valid;
	logic                     ready;
	op_t                      op;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

// ----- rtl/bdws_out_if.sv -----
// Response channel of the deque: valid/ready with status, search result, length.
// Depends on bdws_pkg.
`timescale 1ns / 1ps

interface bdws_out_if import bdws_pkg::*; ();
	logic             valid;
	logic             ready;
	status_t          status;
	logic             found;
	logic [POS_W-1:0] position;
	logic [LEN_W-1:0] length;

	modport source (output valid, output status, output found, output position,
		output length, input ready);
	modport sink (input valid, input status, input found, input position,
		input length, output ready);
endinterface

// ----- rtl/bdws_mem.sv -----
// Entry store of the deque: one write port, one read port, registered read data.
// Depends on bdws_pkg for the word width.
`timescale 1ns / 1ps

module bdws_mem import bdws_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/bounded_deque_with_search_top.sv -----
// Bounded deque with linear search, entries held in a single-port-read memory.
// Each item is captured, executed, and its result passed from ST_RESP to the output
// register once that is free; a search first scans from the front, one read of the
// store per cycle, up to the first match or the last entry held. A new item is taken
// only once the result of the last one has been loaded into the output register.
// Reset clears pointers, occupancy and handshakes; the store itself is not cleared.
`timescale 1ns / 1ps

module bounded_deque_with_search_top import bdws_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bdws_in_if.sink     req,
	bdws_out_if.source  rsp
);

	// Slot index and occupancy widths follow from the depth
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int POS_EXT_W = (IDX_W > POS_W) ? IDX_W : POS_W;
	localparam int LEN_EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

	state_t state_q, state_d;

	// Captured item
	op_t               op_q;
	logic [WORD_W-1:0] key_q;

	// Sequence bookkeeping
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] occ_q, occ_d;

	// Scan position: slot read last cycle and its index from the front
	logic [IDX_W-1:0] slot_q, slot_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	// Finished result, held until the output register is free
	status_t          res_status_q, res_status_d;
	logic             res_found_q, res_found_d;
	logic [IDX_W-1:0] res_pos_q, res_pos_d;
	logic             res_load;

	// Output register
	logic             rsp_valid_q;
	status_t          rsp_status_q;
	logic             rsp_found_q;
	logic [POS_W-1:0] rsp_position_q;
	logic [LEN_W-1:0] rsp_length_q;

	logic out_free;
	logic out_load;
	logic cap_en;

	// Memory access
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data;

	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W-1:0] slot_inc;
	logic             seq_full;
	logic             seq_empty;
	logic             scan_last;

	logic [POS_EXT_W-1:0] pos_ext;
	logic [LEN_EXT_W-1:0] len_ext;

	bdws_mem #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (key_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Circular slot arithmetic without a divider: wrap by compare
	assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - 1'b1;
	assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + 1'b1;
	assign slot_inc  = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
	assign seq_full  = (occ_q == FULL_CNT);
	assign seq_empty = (occ_q == '0);
	// The entry now on the read port is the last one held
	assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == occ_q);

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			occ_q   <= occ_d;
		end
	end

	// Next state, store updates and scan control
	always_comb begin
		state_d      = state_q;
		front_d      = front_q;
		occ_d        = occ_q;
		slot_d       = slot_q;
		idx_d        = idx_q;
		res_load     = 1'b0;
		res_status_d = STS_DONE;
		res_found_d  = 1'b0;
		res_pos_d    = '0;
		out_load     = 1'b0;
		cap_en       = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = front_dec;
		rd_addr      = slot_inc;

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					cap_en  = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				res_load = 1'b1;
				state_d  = ST_RESP;
				case (op_q)
					OP_PUSH_FRONT: begin
						if (seq_full) begin
							res_status_d = STS_FULL;
						end else begin
							wr_en   = 1'b1;
							front_d = front_dec;
							occ_d   = occ_q + 1'b1;
						end
					end
					OP_POP_FRONT: begin
						if (seq_empty) begin
							res_status_d = STS_EMPTY;
						end else begin
							front_d = front_inc;
							occ_d   = occ_q - 1'b1;
						end
					end
					OP_POP_BACK: begin
						if (seq_empty) begin
							res_status_d = STS_EMPTY;
						end else begin
							occ_d = occ_q - 1'b1;
						end
					end
					default: begin
						// Search: start reading at the front unless nothing is held
						if (!seq_empty) begin
							res_load = 1'b0;
							rd_addr  = front_q;
							slot_d   = front_q;
							idx_d    = '0;
							state_d  = ST_SCAN;
						end
					end
				endcase
			end
			ST_SCAN: begin
				if (rd_data == key_q) begin
					res_load    = 1'b1;
					res_found_d = 1'b1;
					res_pos_d   = idx_q;
					state_d     = ST_RESP;
				end else if (scan_last) begin
					res_load = 1'b1;
					state_d  = ST_RESP;
				end else begin
					// Advance: issue the next slot while this one is compared
					rd_addr = slot_inc;
					slot_d  = slot_inc;
					idx_d   = idx_q + 1'b1;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Payload registers: item capture, scan position, pending result
	always_ff @(posedge clk) begin
		if (cap_en) begin
			op_q  <= req.op;
			key_q <= req.value;
		end
		slot_q <= slot_d;
		idx_q  <= idx_d;
		if (res_load) begin
			res_status_q <= res_status_d;
			res_found_q  <= res_found_d;
			res_pos_q    <= res_pos_d;
		end
	end

	// Position and length leave masked to the port widths
	assign pos_ext = POS_EXT_W'(res_pos_q);
	assign len_ext = LEN_EXT_W'(occ_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_status_q   <= res_status_q;
			rsp_found_q    <= res_found_q;
			rsp_position_q <= pos_ext[POS_W-1:0];
			rsp_length_q   <= len_ext[LEN_W-1:0];
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.found    = rsp_found_q;
	assign rsp.position = rsp_position_q;
	assign rsp.length   = rsp_length_q;

endmodule

// ----- rtl/bdws_checker.sv -----
// Port-level checks for the deque, bound to the top level.
// Depends on bdws_pkg and bounded_deque_with_search_top_macros.svh.
`timescale 1ns / 1ps
`include "bounded_deque_with_search_top_macros.svh"

module bdws_checker import bdws_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  logic [1:0]       rsp_status,
	input  logic             rsp_found,
	input  logic [POS_W-1:0] rsp_position
);

	// Hold a stalled response
	`BDWS_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
	// No response while in reset
	`BDWS_ASSERT_ANY(a_rsp_reset, !arst_n |-> !rsp_valid, "response valid during reset")
	// A miss or a non-search item reports position zero
	`BDWS_ASSERT_CLK(a_pos_miss, rsp_valid && !rsp_found |-> rsp_position == '0, "position set without a match")
	// A match only comes with a plain done status
	`BDWS_ASSERT_CLK(a_found_done, rsp_valid && rsp_found |-> rsp_status == STS_DONE, "match with error status")

endmodule

bind bounded_deque_with_search_top bdws_checker u_bdws_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_found    (rsp.found),
	.rsp_position (rsp.position)
);

// ----- sim/tb_bounded_deque_with_search_top.sv -----
// Self-checking testbench for bounded_deque_with_search_top: a directed table,
// then phased random traffic, each response checked against a queue-based deque model.
// Depends on bdws_pkg, bdws_in_if, bdws_out_if and the top level of the block.
`timescale 1ns / 1ps

module tb_bounded_deque_with_search_top;
	import bdws_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int RAND_ITEMS  = 1280;
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off, stalls the block
	localparam int IDLE_LIMIT  = 4000;  // cycles with no item moving on either side
	localparam int TAIL_CYCLES = DEPTH + 8;

	// One response as the block reports it
	typedef struct packed {
		status_t          status;
		logic             found;
		logic [POS_W-1:0] position;
		logic [LEN_W-1:0] length;
	} deque_rsp_t;

	// One row of the directed table; has_rsp marks a response typed in by hand
	typedef struct packed {
		op_t         op;
		logic [31:0] value;
		logic        has_rsp;
		deque_rsp_t  rsp;
	} stim_row_t;

	typedef enum logic [1:0] {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED
	} phase_t;

	localparam int DIR_ROWS = 23;

	// Front of the sequence is the most recent push. After the first four pushes the
	// sequence reads, front to back: 0, -1, min, max.
	localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
		'{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{STS_EMPTY, 1'b0, 6'd0, 7'd0}},
		'{OP_POP_BACK,   32'h0000_0000, 1'b1, '{STS_EMPTY, 1'b0, 6'd0, 7'd0}},
		'{OP_SEARCH,     32'h0000_0000, 1'b1, '{STS_DONE,  1'b0, 6'd0, 7'd0}},
		'{OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, '{STS_DONE,  1'b0, 6'd0, 7'd1}},
		'{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{STS_DONE,  1'b0, 6'd0, 7'd2}},
		'{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '{STS_DONE,  1'b0, 6'd0, 7'd3}},
		'{OP_PUSH_FRONT, 32'h0000_0000, 1'b1, '{STS_DONE,  1'b0, 6'd0, 7'd4}},
		'{OP_SEARCH,     32'h7FFF_FFFF, 1'b1, '{STS_DONE,  1'b1, 6'd3, 7'd4}},
		'{OP_SEARCH,     32'h0000_0000, 1'b1, '{STS_DONE,  1'b1, 6'd0, 7'd4}},
		'{OP_SEARCH,     32'h8000_0000, 1'b1, '{STS_DONE,  1'b1, 6'd2, 7'd4}},
		'{OP_SEARCH,     32'h1234_5678, 1'b1, '{STS_DONE,  1'b0, 6'd0, 7'd4}},
		'{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '{STS_DONE,  1'b0, 6'd0, 7'd5}},
		'{OP_SEARCH,     32'hFFFF_FFFF, 1'b1, '{STS_DONE,  1'b1, 6'd0, 7'd5}},
		'{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{STS_DONE,  1'b0, 6'd0, 7'd4}},
		'{OP_SEARCH,     32'hFFFF_FFFF, 1'b1, '{STS_DONE,  1'b1, 6'd1, 7'd4}},
		'{OP_POP_BACK,   32'h0000_0000, 1'b1, '{STS_DONE,  1'b0, 6'd0, 7'd3}},
		'{OP_SEARCH,     32'h7FFF_FFFF, 1'b1, '{STS_DONE,  1'b0, 6'd0, 7'd3}},
		'{OP_POP_BACK,   32'hA5A5_5A5A, 1'b0, '0},
		'{OP_POP_FRONT,  32'h5A5A_A5A5, 1'b0, '0},
		'{OP_POP_FRONT,  32'hFFFF_FFFF, 1'b1, '{STS_DONE,  1'b0, 6'd0, 7'd0}},
		'{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{STS_EMPTY, 1'b0, 6'd0, 7'd0}},
		'{OP_PUSH_FRONT, 32'h5555_AAAA, 1'b0, '0},
		'{OP_SEARCH,     32'h5555_AAAA, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	bdws_in_if  req_if ();
	bdws_out_if rsp_if ();

	bounded_deque_with_search_top #(
		.DEPTH (DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Deque model: front of the queue is the front of the sequence
	logic [WORD_W-1:0] seq_model [$];
	// Responses owed by the block, oldest first
	deque_rsp_t        owed_rsp [$];

	int fail_cnt;
	int burst_left;
	int hold_trig;   // bumped by the sender to request one long hold-off
	int hold_seen;
	int hold_left;
	int rx_mode;
	int rx_mode_left;
	int rx_cyc;
	int idle_cycles;

	// Clock: 8 ns period
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one operation to the deque model and return the response it owes
	function automatic deque_rsp_t apply_op(input op_t op, input logic [WORD_W-1:0] word);
		deque_rsp_t r;
		r = '{STS_DONE, 1'b0, '0, '0};
		case (op)
			OP_PUSH_FRONT: begin
				if (seq_model.size() >= DEPTH)
					r.status = STS_FULL;
				else
					seq_model.insert(0, word);
			end
			OP_POP_FRONT: begin
				if (seq_model.size() == 0)
					r.status = STS_EMPTY;
				else
					seq_model.delete(0);
			end
			OP_POP_BACK: begin
				if (seq_model.size() == 0)
					r.status = STS_EMPTY;
				else
					seq_model.delete(seq_model.size() - 1);
			end
			default: begin
				// first match from the front wins
				for (int i = 0; i < seq_model.size(); i++) begin
					if (seq_model[i] == word) begin
						r.found    = 1'b1;
						r.position = POS_W'(i);
						break;
					end
				end
			end
		endcase
		r.length = LEN_W'(seq_model.size());
		return r;
	endfunction

	// Word for a push: extremes, a small set to breed duplicates, or anything
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 11))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'hFFFF_FFFF;
			3, 4:    return WORD_W'($urandom_range(0, 7));
			5:       return -WORD_W'($urandom_range(1, 4));
			default: return $urandom();
		endcase
	endfunction

	// Key for a search: mostly a word held in the sequence, the back one now and then
	function automatic logic [WORD_W-1:0] pick_key();
		int n;
		n = seq_model.size();
		if (n != 0 && $urandom_range(0, 9) < 6) begin
			if ($urandom_range(0, 3) == 0)
				return seq_model[n - 1];
			return seq_model[$urandom_range(0, n - 1)];
		end
		return pick_word();
	endfunction

	function automatic op_t pick_op(input phase_t ph);
		int roll;
		roll = $urandom_range(0, 99);
		case (ph)
			PH_FILL: begin
				if (roll < 80) return OP_PUSH_FRONT;
				if (roll < 93) return OP_SEARCH;
				return (roll < 97) ? OP_POP_FRONT : OP_POP_BACK;
			end
			PH_DRAIN: begin
				if (roll < 40) return OP_POP_FRONT;
				if (roll < 78) return OP_POP_BACK;
				return (roll < 92) ? OP_SEARCH : OP_PUSH_FRONT;
			end
			default: return op_t'(roll % 4);
		endcase
	endfunction

	// Offer one item and hold it until taken; on acceptance, log its response.
	// Called at a rising edge; valid gets a single assignment in this step.
	task automatic send_item(input op_t op, input logic [WORD_W-1:0] word,
			input logic has_rsp, input deque_rsp_t typed_rsp);
		deque_rsp_t predicted;
		if (burst_left == 0) begin
			// close the burst with a gap, or none at all now and then
			if ($urandom_range(0, 3) != 0) begin
				req_if.valid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.op    <= op;
		req_if.value <= word;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		predicted = apply_op(op, word);
		owed_rsp.push_back(has_rsp ? typed_rsp : predicted);
	endtask

	// Drop valid and wait until every owed response has come back
	task automatic drain_block();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (owed_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: changes its stall pattern every so often; a request from the
	// sender starts one long hold-off, counted here.
	initial begin
		rsp_if.ready = 1'b0;
		hold_seen    = 0;
		hold_left    = 0;
		rx_mode      = 0;
		rx_mode_left = 0;
		rx_cyc       = 0;
		forever begin
			@(posedge clk);
			rx_cyc++;
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (hold_seen != hold_trig) begin
				hold_seen = hold_trig;
				hold_left = HOLD_CYCLES;
				rsp_if.ready <= 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode      = $urandom_range(0, 3);
					rx_mode_left = $urandom_range(30, 200);
				end else begin
					rx_mode_left--;
				end
				case (rx_mode)
					0:       rsp_if.ready <= 1'b1;
					1:       rsp_if.ready <= $urandom_range(0, 1);
					2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_if.ready <= (rx_cyc % 5 != 0);
				endcase
			end
		end
	end

	// Compare every response taken with the oldest one owed
	always @(posedge clk) begin
		deque_rsp_t owed;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (owed_rsp.size() == 0) begin
				$error("response with none owed: status %0d length %0d",
					rsp_if.status, rsp_if.length);
				fail_cnt++;
			end else begin
				owed = owed_rsp[0];
				owed_rsp.delete(0);
				if (rsp_if.status !== owed.status) begin
					$error("status: expected %0d, got %0d", owed.status, rsp_if.status);
					fail_cnt++;
				end
				if (rsp_if.found !== owed.found) begin
					$error("found: expected %0d, got %0d", owed.found, rsp_if.found);
					fail_cnt++;
				end
				if (rsp_if.position !== owed.position) begin
					$error("position: expected %0d, got %0d", owed.position,
						rsp_if.position);
					fail_cnt++;
				end
				if (rsp_if.length !== owed.length) begin
					$error("length: expected %0d, got %0d", owed.length, rsp_if.length);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves on either side for too long
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_bounded_deque_with_search_top NOT OK");
			$finish;
		end
	end

	initial begin
		phase_t ph;
		int     phase_left;
		int     sent;
		op_t    op;
		bit     first_phase;

		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.op    = OP_PUSH_FRONT;
		req_if.value = '0;
		fail_cnt     = 0;
		burst_left   = 0;
		hold_trig    = 0;
		idle_cycles  = 0;

		// Hold reset, then release it on a clock edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty pops, extremes, duplicates, first-match order
		for (int r = 0; r < DIR_ROWS; r++)
			send_item(DIR_TAB[r].op, DIR_TAB[r].value, DIR_TAB[r].has_rsp, DIR_TAB[r].rsp);

		// Random part in phases: fill to full and past it, drain to empty and
		// past it, and mixed traffic between
		sent        = 0;
		phase_left  = 0;
		ph          = PH_FILL;
		first_phase = 1'b1;
		while (sent < RAND_ITEMS) begin
			if (phase_left == 0) begin
				// pause at a phase boundary until the block has caught up
				if (first_phase || $urandom_range(0, 3) == 0)
					drain_block();
				first_phase = 1'b0;
				ph          = phase_t'($urandom_range(0, 2));
				phase_left  = $urandom_range(40, 120);
			end
			// once, stall the receiver long while items keep being offered
			if (sent == 250)
				hold_trig++;
			op = pick_op(ph);
			if (op == OP_SEARCH)
				send_item(op, pick_key(), 1'b0, '0);
			else if (op == OP_PUSH_FRONT)
				send_item(op, pick_word(), 1'b0, '0);
			else
				send_item(op, $urandom(), 1'b0, '0);
			sent++;
			phase_left--;
		end

		// Wait for the last responses, then watch a little longer for strays
		drain_block();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("tb_bounded_deque_with_search_top OK");
		else
			$display("tb_bounded_deque_with_search_top NOT OK");
		$finish;
	end

endmodule
